/* src/hpm_pkg.sv */
`timescale 1ns / 1ps

package hpm_pkg;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_TAKE     = 2'd0,
        OP_FEEDBACK = 2'd1,
        OP_RECEIVE  = 2'd2,
        OP_NONE     = 2'd3
    } hpm_op_t;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_NEW      = 3'd0,
        KIND_RETX     = 3'd1,
        KIND_ACK_FREE = 3'd2,
        KIND_MAX_FREE = 3'd3,
        KIND_NO_FREE  = 3'd4,
        KIND_RX       = 3'd5,
        KIND_INVALID  = 3'd6
    } hpm_kind_t;

    // Configuration register indexes.
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_MAX_TX   = 1'b1;

    localparam logic [19:0] CAP_RESET   = 20'd4096;
    localparam logic [3:0]  MAXTX_RESET = 4'd4;

    // Smallest bucket bound is 16 bytes, the largest 131072 bytes.
    localparam logic [19:0] BUCKET_BASE = 20'd16;
    localparam int          BUCKET_TOP  = 14;
    localparam logic [3:0]  BUCKET_OVER = 4'hf;

    typedef struct packed {
        hpm_op_t     op;
        logic [3:0]  proc_number;
        logic        fb_format_in;
        logic        ack_bit;
        logic [15:0] pkt_bytes;
    } hpm_item_t;

    typedef struct packed {
        hpm_kind_t   kind;
        logic [3:0]  out_process;
        logic [1:0]  rv_value;
        logic        new_data_flag;
        logic [3:0]  tx_count;
        logic        fb_format_out;
        logic [3:0]  buf_level;
    } hpm_result_t;

    // Outcome of the free-process search.
    typedef struct packed {
        logic       found;
        logic [3:0] index;
    } hpm_free_t;

    // Redundancy version sequence 0 -> 2 -> 3 -> 1 -> 0.
    function automatic logic [1:0] next_rv(input logic [1:0] rv);
        logic [1:0] nxt;
        unique case (rv)
            2'd0:    nxt = 2'd2;
            2'd1:    nxt = 2'd0;
            2'd2:    nxt = 2'd3;
            default: nxt = 2'd1;
        endcase
        return nxt;
    endfunction

    // Log2 bucket of the remaining buffer: 0 when empty, k when at most
    // 2^(k+3) bytes remain, 15 when more than the top bucket remain.
    function automatic logic [3:0] status_bucket(input logic [19:0] bytes);
        logic [3:0] bucket;
        bucket = BUCKET_OVER;
        for (int k = BUCKET_TOP; k >= 1; k--) begin
            if (bytes <= (BUCKET_BASE << (k - 1))) begin
                bucket = 4'(k);
            end
        end
        if (bytes == 20'd0) begin
            bucket = 4'd0;
        end
        return bucket;
    endfunction

endpackage

/* src/hpm_if.sv */
`timescale 1ns / 1ps

// Request channel: one event per beat.
interface hpm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [3:0]  proc_number;
    logic        fb_format_in;
    logic        ack_bit;
    logic [15:0] pkt_bytes;

    modport source (
        output valid, op, proc_number, fb_format_in, ack_bit, pkt_bytes,
        input  ready
    );
    modport sink (
        input  valid, op, proc_number, fb_format_in, ack_bit, pkt_bytes,
        output ready
    );
endinterface

// Response channel: one result per beat.
interface hpm_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] out_process;
    logic [1:0] rv_value;
    logic       new_data_flag;
    logic [3:0] tx_count;
    logic       fb_format_out;
    logic [3:0] buf_level;

    modport source (
        output valid, kind, out_process, rv_value, new_data_flag,
               tx_count, fb_format_out, buf_level,
        input  ready
    );
    modport sink (
        input  valid, kind, out_process, rv_value, new_data_flag,
               tx_count, fb_format_out, buf_level,
        output ready
    );
endinterface

/* src/harq_process_manager.sv */
`timescale 1ns / 1ps
// Flow: an accepted request beat waits in the input register; its result then goes to the
// result register, which drives the response channel.
// Throughput: one request per cycle unless results stall; the process table is updated as
// the request leaves the input register, so the next request already sees the new state.
// Reset: every process free with its new-data bit set, version and count zero, 4096 bytes
// of buffer; capacity 4096 and four transmissions allowed. Ready returns straight after reset.

module harq_process_manager #(
    parameter int PROCESS_COUNT = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [19:0]        cfg_wdata,
    hpm_req_if.sink            req,
    hpm_rsp_if.source          rsp
);

    localparam int IDX_W = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;

    // Configuration registers.
    logic [19:0] capacity_reg;
    logic [3:0]  max_tx_reg;

    // Process table, one entry per process.
    logic [PROCESS_COUNT-1:0] occupied_reg;
    logic [PROCESS_COUNT-1:0] ndi_reg;
    logic [1:0]               rv_reg     [PROCESS_COUNT];
    logic [3:0]               count_reg  [PROCESS_COUNT];
    logic [19:0]              buffer_reg [PROCESS_COUNT];

    // Input register and result register.
    logic                 s1_valid_reg;
    hpm_pkg::hpm_item_t   s1_item_reg;
    logic                 res_valid_reg;
    hpm_pkg::hpm_result_t res_reg;
    hpm_pkg::hpm_result_t res_next;
    logic                 res_produce;

    // Next value of the one table entry that an event touches.
    logic             entry_we;
    logic             occupied_next;
    logic             ndi_next;
    logic [1:0]       rv_next;
    logic [3:0]       count_next;
    logic [19:0]      buffer_next;

    logic             advance;
    hpm_pkg::hpm_free_t free_info;
    logic [IDX_W-1:0] sel_idx;
    logic             proc_ok;

    // Values read from the selected entry.
    logic             rd_occupied;
    logic             rd_ndi;
    logic [1:0]       rd_rv;
    logic [3:0]       rd_count;
    logic [19:0]      rd_buffer;

    logic [1:0]       nack_rv;
    logic [19:0]      bytes_ext;
    logic [19:0]      bucket_src;

    hpm_free_finder #(
        .PROCESS_COUNT (PROCESS_COUNT)
    ) u_free_finder (
        .occupied (occupied_reg),
        .result   (free_info)
    );

    // The input register moves on whenever the result register is empty or being
    // emptied in the same cycle; an ignored request simply leaves.
    assign advance   = s1_valid_reg && (!res_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;

    // A take works on the lowest free process, everything else on the named one.
    assign sel_idx = (s1_item_reg.op == hpm_pkg::OP_TAKE)
                   ? free_info.index[IDX_W-1:0]
                   : s1_item_reg.proc_number[IDX_W-1:0];
    assign proc_ok = (int'(s1_item_reg.proc_number) < PROCESS_COUNT);

    assign rd_occupied = occupied_reg[sel_idx];
    assign rd_ndi      = ndi_reg[sel_idx];
    assign rd_rv       = rv_reg[sel_idx];
    assign rd_count    = count_reg[sel_idx];
    assign rd_buffer   = buffer_reg[sel_idx];

    assign bytes_ext = {4'd0, s1_item_reg.pkt_bytes};
    // A buffer-too-small NACK restarts the version sequence.
    assign nack_rv   = s1_item_reg.fb_format_in ? 2'd0 : hpm_pkg::next_rv(rd_rv);

    // Event handling. The buffer status always reports one value, chosen here, so a
    // single bucket encoder serves every kind of result.
    always_comb
    begin
        res_next      = '0;
        res_next.kind = hpm_pkg::KIND_INVALID;
        res_produce   = 1'b1;
        entry_we      = 1'b0;
        occupied_next = rd_occupied;
        ndi_next      = rd_ndi;
        rv_next       = rd_rv;
        count_next    = rd_count;
        buffer_next   = rd_buffer;
        bucket_src    = 20'd0;

        unique case (s1_item_reg.op)
            hpm_pkg::OP_TAKE:
            begin
                if (free_info.found) begin
                    entry_we               = 1'b1;
                    occupied_next          = 1'b1;
                    ndi_next               = !rd_ndi;
                    count_next             = 4'd1;
                    bucket_src             = rd_buffer;
                    res_next.kind          = hpm_pkg::KIND_NEW;
                    res_next.out_process   = free_info.index;
                    res_next.rv_value      = rd_rv;
                    res_next.new_data_flag = !rd_ndi;
                    res_next.tx_count      = 4'd1;
                end
                else begin
                    res_next.kind = hpm_pkg::KIND_NO_FREE;
                end
            end
            hpm_pkg::OP_FEEDBACK:
            begin
                res_next.out_process = s1_item_reg.proc_number;
                if (proc_ok && rd_occupied) begin
                    entry_we               = 1'b1;
                    res_next.new_data_flag = rd_ndi;
                    if (!s1_item_reg.fb_format_in && s1_item_reg.ack_bit) begin
                        occupied_next = 1'b0;
                        rv_next       = 2'd0;
                        count_next    = 4'd0;
                        buffer_next   = capacity_reg;
                        bucket_src    = capacity_reg;
                        res_next.kind = hpm_pkg::KIND_ACK_FREE;
                    end
                    else if (rd_count < max_tx_reg) begin
                        rv_next           = nack_rv;
                        count_next        = rd_count + 4'd1;
                        bucket_src        = rd_buffer;
                        res_next.kind     = hpm_pkg::KIND_RETX;
                        res_next.rv_value = nack_rv;
                        res_next.tx_count = rd_count + 4'd1;
                    end
                    else begin
                        occupied_next = 1'b0;
                        rv_next       = 2'd0;
                        count_next    = 4'd0;
                        buffer_next   = capacity_reg;
                        bucket_src    = capacity_reg;
                        res_next.kind = hpm_pkg::KIND_MAX_FREE;
                    end
                end
            end
            hpm_pkg::OP_RECEIVE:
            begin
                res_next.out_process = s1_item_reg.proc_number;
                if (proc_ok) begin
                    entry_we = 1'b1;
                    // Nothing is taken from a buffer too small for the packet.
                    if (rd_buffer >= bytes_ext) begin
                        buffer_next = rd_buffer - bytes_ext;
                    end
                    bucket_src             = buffer_next;
                    res_next.kind          = hpm_pkg::KIND_RX;
                    res_next.fb_format_out = (bytes_ext > capacity_reg);
                end
            end
            hpm_pkg::OP_NONE:
            begin
                res_produce = 1'b0;
            end
        endcase

        res_next.buf_level = hpm_pkg::status_bucket(bucket_src);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity_reg <= hpm_pkg::CAP_RESET;
            max_tx_reg   <= hpm_pkg::MAXTX_RESET;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                hpm_pkg::REG_CAPACITY: capacity_reg <= cfg_wdata;
                hpm_pkg::REG_MAX_TX:   max_tx_reg   <= cfg_wdata[3:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            occupied_reg <= '0;
            ndi_reg      <= '1;
            for (int i = 0; i < PROCESS_COUNT; i++) begin
                rv_reg[i]     <= 2'd0;
                count_reg[i]  <= 4'd0;
                buffer_reg[i] <= hpm_pkg::CAP_RESET;
            end
        end
        else if (advance && entry_we) begin
            occupied_reg[sel_idx] <= occupied_next;
            ndi_reg[sel_idx]      <= ndi_next;
            rv_reg[sel_idx]       <= rv_next;
            count_reg[sel_idx]    <= count_next;
            buffer_reg[sel_idx]   <= buffer_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else begin
            if (req.valid && req.ready) begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance) begin
                s1_valid_reg <= 1'b0;
            end

            if (advance) begin
                res_valid_reg <= res_produce;
            end
            else if (rsp.ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready) begin
            s1_item_reg.op           <= hpm_pkg::hpm_op_t'(req.op);
            s1_item_reg.proc_number  <= req.proc_number;
            s1_item_reg.fb_format_in <= req.fb_format_in;
            s1_item_reg.ack_bit      <= req.ack_bit;
            s1_item_reg.pkt_bytes    <= req.pkt_bytes;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid         = res_valid_reg;
    assign rsp.kind          = res_reg.kind;
    assign rsp.out_process   = res_reg.out_process;
    assign rsp.rv_value      = res_reg.rv_value;
    assign rsp.new_data_flag = res_reg.new_data_flag;
    assign rsp.tx_count      = res_reg.tx_count;
    assign rsp.fb_format_out = res_reg.fb_format_out;
    assign rsp.buf_level     = res_reg.buf_level;

    // While a "no free process" result waits, the table cannot have changed.
    a_no_free_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.kind == hpm_pkg::KIND_NO_FREE) |-> (&occupied_reg))
        else $error("no-free result while a process is free");

    // A successful take leaves the claimed process occupied.
    a_take_claims: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.op == hpm_pkg::OP_TAKE && free_info.found)
        |=> occupied_reg[$past(sel_idx)])
        else $error("taken process not marked occupied");

    // A new transmission always starts with a count of one.
    a_new_count_one: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.kind == hpm_pkg::KIND_NEW)
        |-> (res_reg.tx_count == 4'd1 && !res_reg.fb_format_out))
        else $error("new transmission with wrong count or format");

    // A held request only blocks the input while the result register is stalled.
    a_ready_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && res_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("request taken while the pipeline is stalled");

endmodule

/* src/hpm_free_finder.sv */
`timescale 1ns / 1ps

// Finds the lowest-numbered free process.
module hpm_free_finder #(
    parameter int PROCESS_COUNT = 8
) (
    input  logic [PROCESS_COUNT-1:0] occupied,
    output hpm_pkg::hpm_free_t       result
);

    always_comb
    begin
        result = '0;
        for (int i = PROCESS_COUNT - 1; i >= 0; i--) begin
            if (!occupied[i]) begin
                result.found = 1'b1;
                result.index = 4'(i);
            end
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int POOL_SIZE = 8;
    localparam int PHASE_EVENTS = 190;
    localparam int GAP_PERCENT = 27;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [19:0] cfg_wdata;

    hpm_req_if req_ch ();
    hpm_rsp_if rsp_ch ();

    harq_process_manager #(
        .PROCESS_COUNT (POOL_SIZE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Our own copy of the process pool, mirrored from every accepted request beat.
    logic        busy      [POOL_SIZE];
    logic        ndi_state [POOL_SIZE];
    logic [1:0]  rv_state  [POOL_SIZE];
    logic [3:0]  tx_cnt    [POOL_SIZE];
    logic [19:0] soft_left [POOL_SIZE];
    logic [19:0] capacity;
    logic [3:0]  max_tx;

    hpm_pkg::hpm_item_t   pending_events [$];
    hpm_pkg::hpm_result_t awaited_results [$];
    hpm_pkg::hpm_item_t   beat_on_bus;

    // Set by the stimulus for one whole phase, so that both sides run back to back.
    bit          steady_flow;
    int          mismatch_count;
    int          events_accepted;
    int          results_checked;
    int          kind_seen [7];

    always #2 clk = ~clk;

    // Log2 bucket of a soft-buffer level: 0 when empty, k when the level is at
    // most 2^(k+3) bytes, 15 above 131072 bytes.
    function automatic logic [3:0] buffer_bucket(input logic [19:0] level);
        logic [20:0] bound;
        if (level == 20'd0)
        begin
            return 4'd0;
        end
        bound = 21'd16;
        for (int k = 1; k <= 14; k++)
        begin
            if ({1'b0, level} <= bound)
            begin
                return 4'(k);
            end
            bound = bound << 1;
        end
        return 4'hf;
    endfunction

    // A plain NACK walks the redundancy version through 0, 2, 3, 1 and back to 0.
    function automatic logic [1:0] rv_after_nack(input logic [1:0] rv);
        case (rv)
            2'd0:    return 2'd2;
            2'd2:    return 2'd3;
            2'd3:    return 2'd1;
            default: return 2'd0;
        endcase
    endfunction

    // Releasing keeps the new-data bit but reloads the buffer from the current capacity.
    function automatic void free_process(input int unsigned p);
        busy[p]      = 1'b0;
        rv_state[p]  = 2'd0;
        tx_cnt[p]    = 4'd0;
        soft_left[p] = capacity;
    endfunction

    // Applies one request to the mirrored pool and works out the response beat it causes.
    // Returns 0 for the unused operation code, which the block silently drops.
    function automatic bit predict_event(input hpm_pkg::hpm_item_t ev,
                                         output hpm_pkg::hpm_result_t res);
        int unsigned p;
        bit          found;
        res = '0;
        p = 32'(ev.proc_number);
        found = 1'b0;
        if (ev.op == hpm_pkg::OP_NONE)
        begin
            return 1'b0;
        end
        if (ev.op == hpm_pkg::OP_TAKE)
        begin
            // Lowest-numbered free process wins.
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                if (!found && !busy[i])
                begin
                    found             = 1'b1;
                    busy[i]           = 1'b1;
                    ndi_state[i]      = ~ndi_state[i];
                    tx_cnt[i]         = 4'd1;
                    res.kind          = hpm_pkg::KIND_NEW;
                    res.out_process   = 4'(i);
                    res.rv_value      = rv_state[i];
                    res.new_data_flag = ndi_state[i];
                    res.tx_count      = 4'd1;
                    res.buf_level     = buffer_bucket(soft_left[i]);
                end
            end
            if (!found)
            begin
                res.kind = hpm_pkg::KIND_NO_FREE;
            end
            return 1'b1;
        end
        res.out_process = ev.proc_number;
        // Out-of-range process numbers, and feedback for a process not in use, change nothing.
        if (p >= POOL_SIZE || (ev.op == hpm_pkg::OP_FEEDBACK && !busy[p]))
        begin
            res.kind = hpm_pkg::KIND_INVALID;
            return 1'b1;
        end
        if (ev.op == hpm_pkg::OP_FEEDBACK)
        begin
            if (!ev.fb_format_in && ev.ack_bit)
            begin
                free_process(p);
                res.kind          = hpm_pkg::KIND_ACK_FREE;
                res.new_data_flag = ndi_state[p];
                res.buf_level     = buffer_bucket(soft_left[p]);
                return 1'b1;
            end
            // A buffer-too-small NACK restarts the version sequence; the ACK bit is ignored.
            rv_state[p] = ev.fb_format_in ? 2'd0 : rv_after_nack(rv_state[p]);
            if (tx_cnt[p] < max_tx)
            begin
                tx_cnt[p]         = tx_cnt[p] + 4'd1;
                res.kind          = hpm_pkg::KIND_RETX;
                res.rv_value      = rv_state[p];
                res.new_data_flag = ndi_state[p];
                res.tx_count      = tx_cnt[p];
            end
            else
            begin
                free_process(p);
                res.kind          = hpm_pkg::KIND_MAX_FREE;
                res.new_data_flag = ndi_state[p];
            end
            res.buf_level = buffer_bucket(soft_left[p]);
            return 1'b1;
        end
        // Receive request: deduct only when the whole packet fits in what is left.
        if (soft_left[p] >= {4'd0, ev.pkt_bytes})
        begin
            soft_left[p] = soft_left[p] - {4'd0, ev.pkt_bytes};
        end
        res.kind          = hpm_pkg::KIND_RX;
        res.fb_format_out = ({4'd0, ev.pkt_bytes} > capacity);
        res.buf_level     = buffer_bucket(soft_left[p]);
        return 1'b1;
    endfunction

    function automatic bit take_gap();
        return !steady_flow && ($urandom_range(99) < GAP_PERCENT);
    endfunction

    // Request driver: a beat stays on the bus until it is accepted, then the next one
    // is taken from the queue unless the sender chooses to idle this cycle.
    always @(posedge clk)
    begin
        hpm_pkg::hpm_result_t res;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                events_accepted++;
                if (predict_event(beat_on_bus, res))
                begin
                    awaited_results.push_back(res);
                end
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_events.size() > 0 && !take_gap())
                begin
                    beat_on_bus         = pending_events.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.op           <= beat_on_bus.op;
                    req_ch.proc_number  <= beat_on_bus.proc_number;
                    req_ch.fb_format_in <= beat_on_bus.fb_format_in;
                    req_ch.ack_bit      <= beat_on_bus.ack_bit;
                    req_ch.pkt_bytes    <= beat_on_bus.pkt_bytes;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input logic [19:0] want,
                                 input logic [19:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Response monitor: every beat taken is checked against the oldest expectation.
    always @(posedge clk)
    begin
        hpm_pkg::hpm_result_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_checked++;
                if (awaited_results.size() == 0)
                begin
                    $error("response beat with no request waiting for it (kind %0d)",
                           rsp_ch.kind);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.kind <= hpm_pkg::KIND_INVALID)
                    begin
                        kind_seen[want.kind]++;
                    end
                    compare_field("kind", 20'(want.kind), 20'(rsp_ch.kind));
                    compare_field("out_process", 20'(want.out_process),
                                  20'(rsp_ch.out_process));
                    compare_field("rv_value", 20'(want.rv_value), 20'(rsp_ch.rv_value));
                    compare_field("new_data_flag", 20'(want.new_data_flag),
                                  20'(rsp_ch.new_data_flag));
                    compare_field("tx_count", 20'(want.tx_count), 20'(rsp_ch.tx_count));
                    compare_field("fb_format_out", 20'(want.fb_format_out),
                                  20'(rsp_ch.fb_format_out));
                    compare_field("buf_level", 20'(want.buf_level), 20'(rsp_ch.buf_level));
                end
            end
            rsp_ch.ready <= !take_gap();
        end
    end

    task automatic push_event(input hpm_pkg::hpm_op_t op, input logic [3:0] proc_number,
                              input logic fmt, input logic ack, input logic [15:0] bytes);
        hpm_pkg::hpm_item_t ev;
        ev.op           = op;
        ev.proc_number  = proc_number;
        ev.fb_format_in = fmt;
        ev.ack_bit      = ack;
        ev.pkt_bytes    = bytes;
        pending_events.push_back(ev);
    endtask

    // Register writes are only made with the pool quiet, so the mirror is updated at once.
    task automatic write_register(input logic idx, input logic [19:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == hpm_pkg::REG_CAPACITY)
        begin
            capacity = value;
        end
        else
        begin
            max_tx = value[3:0];
        end
    endtask

    // Waits until every request has gone out and every response has come back, then
    // lets the pipeline run on in case a dropped request is still inside.
    task automatic wait_quiet();
        do
        begin
            @(negedge clk);
        end
        while (pending_events.size() != 0 || req_ch.valid || awaited_results.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    // Mostly well-formed traffic aimed at processes that exist, with every field
    // carrying random noise underneath and a sprinkling of dropped and invalid requests.
    function automatic hpm_pkg::hpm_item_t random_event();
        hpm_pkg::hpm_item_t ev;
        int                 pick;
        int                 near;
        ev.op           = hpm_pkg::hpm_op_t'($urandom_range(3));
        ev.proc_number  = 4'($urandom);
        ev.fb_format_in = 1'($urandom);
        ev.ack_bit      = 1'($urandom);
        ev.pkt_bytes    = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            ev.op = hpm_pkg::OP_TAKE;
        end
        else if (pick < 97)
        begin
            ev.op = (pick < 65) ? hpm_pkg::OP_FEEDBACK : hpm_pkg::OP_RECEIVE;
            if ($urandom_range(9) != 0)
            begin
                ev.proc_number = 4'($urandom_range(POOL_SIZE - 1));
            end
            ev.fb_format_in = ($urandom_range(4) == 0);
            ev.ack_bit      = ($urandom_range(99) < 45);
            pick = $urandom_range(9);
            if (pick < 4)
            begin
                ev.pkt_bytes = 16'($urandom_range(255));
            end
            else if (pick < 6)
            begin
                near = int'(capacity) + $urandom_range(4) - 2;
                ev.pkt_bytes = (near < 0) ? 16'd0 : (near > 65535) ? 16'hffff : 16'(near);
            end
        end
        else
        begin
            ev.op = hpm_pkg::OP_NONE;
        end
        return ev;
    endfunction

    task automatic queue_random_phase(input int count);
        hpm_pkg::hpm_item_t ev;
        int                 queued;
        queued = 0;
        while (queued < count)
        begin
            ev = random_event();
            pending_events.push_back(ev);
            if (ev.op != hpm_pkg::OP_NONE)
            begin
                queued++;
            end
        end
    endtask

    // Register settings for the random phases; the first phase keeps the reset values.
    logic [19:0] phase_capacity [6] = '{20'hfffff, 20'd0, 20'd100, 20'd65535, 20'd5000, 20'd16};
    logic [3:0]  phase_max_tx   [6] = '{4'd15, 4'd1, 4'd0, 4'd2, 4'd7, 4'd3};

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = hpm_pkg::REG_CAPACITY;
        cfg_wdata      = '0;
        req_ch.valid        = 1'b0;
        req_ch.op           = hpm_pkg::OP_NONE;
        req_ch.proc_number  = '0;
        req_ch.fb_format_in = 1'b0;
        req_ch.ack_bit      = 1'b0;
        req_ch.pkt_bytes    = '0;
        rsp_ch.ready   = 1'b0;
        steady_flow    = 1'b0;
        mismatch_count = 0;
        events_accepted = 0;
        results_checked = 0;
        capacity       = hpm_pkg::CAP_RESET;
        max_tx         = hpm_pkg::MAXTX_RESET;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            busy[i]      = 1'b0;
            ndi_state[i] = 1'b1;
            rv_state[i]  = 2'd0;
            tx_cnt[i]    = 4'd0;
            soft_left[i] = hpm_pkg::CAP_RESET;
        end
        for (int k = 0; k < 7; k++)
        begin
            kind_seen[k] = 0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening at the reset settings. Fill the pool, then ask once more
        // so that no free process is left.
        for (int i = 0; i <= POOL_SIZE; i++)
        begin
            push_event(hpm_pkg::OP_TAKE, 4'd0, 1'b0, 1'b0, 16'd0);
        end
        // Plain NACKs on process 0 walk the version sequence until the transmission
        // limit is reached and the process is given up.
        repeat (4) push_event(hpm_pkg::OP_FEEDBACK, 4'd0, 1'b0, 1'b0, 16'd0);
        // Buffer-too-small NACK with the ACK bit set still counts as a NACK.
        push_event(hpm_pkg::OP_FEEDBACK, 4'd1, 1'b1, 1'b1, 16'd0);
        push_event(hpm_pkg::OP_FEEDBACK, 4'd2, 1'b0, 1'b1, 16'd0);
        // Feedback for a process number beyond the pool, and for one now free.
        push_event(hpm_pkg::OP_FEEDBACK, 4'd15, 1'b1, 1'b1, 16'hffff);
        push_event(hpm_pkg::OP_FEEDBACK, 4'd0, 1'b0, 1'b1, 16'd0);
        // Receive requests: empty packet, oversized packet that cannot be deducted,
        // then one that drains the buffer exactly, and one for a missing process.
        push_event(hpm_pkg::OP_RECEIVE, 4'd3, 1'b0, 1'b0, 16'd0);
        push_event(hpm_pkg::OP_RECEIVE, 4'd3, 1'b1, 1'b1, 16'hffff);
        push_event(hpm_pkg::OP_RECEIVE, 4'd3, 1'b0, 1'b0, 16'd4096);
        push_event(hpm_pkg::OP_RECEIVE, 4'd12, 1'b0, 1'b0, 16'd1);
        // The unused operation code is dropped without a response.
        push_event(hpm_pkg::OP_NONE, 4'd7, 1'b1, 1'b1, 16'h5a5a);
        push_event(hpm_pkg::OP_TAKE, 4'hf, 1'b1, 1'b1, 16'hffff);
        queue_random_phase(PHASE_EVENTS);
        wait_quiet();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_register(hpm_pkg::REG_CAPACITY, phase_capacity[ph]);
            write_register(hpm_pkg::REG_MAX_TX, {16'd0, phase_max_tx[ph]});
            steady_flow = (ph == 3);
            queue_random_phase(PHASE_EVENTS);
            wait_quiet();
            steady_flow = 1'b0;
        end

        $display("Covered %0d request beats and %0d responses over seven register settings.",
                 events_accepted, results_checked);
        $display("Kinds new/retx/ack/max/none/rx/invalid: %0d %0d %0d %0d %0d %0d %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
                 kind_seen[4], kind_seen[5], kind_seen[6]);
        if (mismatch_count == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Safety net should the block stop answering.
    initial
    begin
        #400000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
